@@ src/tcbn_pkg.sv @@
// Shared types, codes and helper functions of the tree center node.
`default_nettype none
package tcbn_pkg;

  localparam int MaxPorts  = 8;
  localparam int ValueBits = 16;

  // Input operation codes
  localparam logic [2:0] OP_START      = 3'd0;
  localparam logic [2:0] OP_ACTIVATE   = 3'd1;
  localparam logic [2:0] OP_SATURATION = 3'd2;
  localparam logic [2:0] OP_CENTER     = 3'd3;
  localparam logic [2:0] OP_TOKEN      = 3'd4;
  localparam logic [2:0] OP_YES        = 3'd5;
  localparam logic [2:0] OP_NO         = 3'd6;

  // Outgoing message kinds
  localparam logic [2:0] KIND_ACTIVATE   = 3'd0;
  localparam logic [2:0] KIND_SATURATION = 3'd1;
  localparam logic [2:0] KIND_CENTER     = 3'd2;
  localparam logic [2:0] KIND_TOKEN      = 3'd3;
  localparam logic [2:0] KIND_YES        = 3'd4;
  localparam logic [2:0] KIND_NO         = 3'd5;
  localparam logic [2:0] KIND_NONE       = 3'd6;

  typedef struct packed {
    logic       is_center;
    logic       bft_done;
    logic [7:0] children;
  } status_t;

  // One classified item: a broadcast over a port mask, then an optional single message
  typedef struct packed {
    logic [7:0]  mask;
    logic [2:0]  bkind;
    logic [15:0] bval;
    logic        ex_en;
    logic [2:0]  ekind;
    logic [2:0]  eport;
    logic [15:0] evalue;
    status_t     status;
  } job_t;

  // Saturating increment
  function automatic logic [15:0] inc16(input logic [15:0] v);
    inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Index of the lowest set bit
  function automatic logic [2:0] lowest_bit(input logic [7:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    lowest_bit = r;
  endfunction

endpackage
`default_nettype wire

@@ src/tcbn_front.sv @@
// Front end: accepts items, updates protocol state and classifies the messages to send.
`default_nettype none
module tcbn_front import tcbn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [2:0]  arrival_port,
  input  wire logic [15:0] value,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic [3:0]  port_count;
  logic [7:0]  pending_ports, pending_ports_next;
  logic [15:0] top_value, top_value_next, second_value, second_value_next;
  logic [2:0]  top_port, top_port_next, sat_parent_port, sat_parent_port_next;
  logic        available_flag, available_flag_next, active_flag, active_flag_next;
  logic        processing_flag, processing_flag_next, center_flag, center_flag_next;
  logic        tree_has_parent, tree_has_parent_next, tree_root, tree_root_next;
  logic [2:0]  tree_parent_port, tree_parent_port_next;
  logic [15:0] tree_level, tree_level_next;
  logic [3:0]  replies_expected, replies_expected_next;
  logic [7:0]  child_mask, child_mask_next;
  logic        done_flag, done_flag_next;

  logic [3:0]  n;
  logic [8:0]  full9;
  logic [7:0]  full, port_bit, rest;
  logic        port_ok;
  logic [15:0] abs_t, abs_s, diff;
  logic [2:0]  abs_p;
  job_t        job;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_job    = job;

  // Port set and folded maximum values
  always_comb begin
    n        = (port_count > 4'd8) ? 4'd8 : port_count;
    full9    = (9'd1 << n) - 9'd1;
    full     = full9[7:0];
    port_bit = 8'd1 << arrival_port;
    port_ok  = ({1'b0, arrival_port} < n);
    abs_t = top_value;
    abs_s = second_value;
    abs_p = top_port;
    if (top_value <= value) begin
      abs_s = top_value;
      abs_t = value;
      abs_p = arrival_port;
    end else if (second_value <= value) begin
      abs_s = value;
    end
    diff = (abs_t >= abs_s) ? abs_t - abs_s : 16'd0;
    rest = pending_ports & ~port_bit;
  end

  // Next state and job classification
  always_comb begin
    pending_ports_next    = pending_ports;
    top_value_next        = top_value;
    second_value_next     = second_value;
    top_port_next         = top_port;
    sat_parent_port_next  = sat_parent_port;
    available_flag_next   = available_flag;
    active_flag_next      = active_flag;
    processing_flag_next  = processing_flag;
    center_flag_next      = center_flag;
    tree_has_parent_next  = tree_has_parent;
    tree_root_next        = tree_root;
    tree_parent_port_next = tree_parent_port;
    tree_level_next       = tree_level;
    replies_expected_next = replies_expected;
    child_mask_next       = child_mask;
    done_flag_next        = done_flag;
    job        = '0;
    job.bkind  = KIND_ACTIVATE;
    job.ekind  = KIND_NONE;

    if (operation == OP_START || (operation == OP_ACTIVATE && port_ok)) begin
      // activation, acted on once
      if (available_flag) begin
        available_flag_next = 1'b0;
        job.mask  = (operation == OP_ACTIVATE) ? (full & ~port_bit) : full;
        job.bkind = KIND_ACTIVATE;
        pending_ports_next = full;
        if (n == 4'd1) begin
          job.ex_en  = 1'b1;
          job.ekind  = KIND_SATURATION;
          job.eport  = 3'd0;
          job.evalue = inc16(top_value);
          sat_parent_port_next = 3'd0;
          processing_flag_next = 1'b1;
        end else begin
          active_flag_next = 1'b1;
        end
      end
    end else if (port_ok) begin
      case (operation)
        OP_SATURATION, OP_CENTER: begin
          top_value_next    = abs_t;
          second_value_next = abs_s;
          top_port_next     = abs_p;
          if (operation == OP_SATURATION && active_flag) begin
            pending_ports_next = rest;
            if (rest != 8'd0 && (rest & (rest - 8'd1)) == 8'd0) begin
              job.ex_en  = 1'b1;
              job.ekind  = KIND_SATURATION;
              job.eport  = lowest_bit(rest);
              job.evalue = inc16(abs_t);
              sat_parent_port_next = lowest_bit(rest);
              processing_flag_next = 1'b1;
              active_flag_next     = 1'b0;
            end
          end else if (operation == OP_CENTER || processing_flag) begin
            // resolve
            if (diff == 16'd1) begin
              center_flag_next = 1'b1;
              if (abs_p != sat_parent_port) begin
                job.ex_en  = 1'b1;
                job.ekind  = KIND_CENTER;
                job.eport  = abs_p;
                job.evalue = inc16(abs_s);
              end
            end else if (diff > 16'd1) begin
              job.ex_en  = 1'b1;
              job.ekind  = KIND_CENTER;
              job.eport  = abs_p;
              job.evalue = inc16(abs_s);
            end else begin
              center_flag_next      = 1'b1;
              tree_has_parent_next  = 1'b1;
              tree_root_next        = 1'b1;
              tree_level_next       = 16'd0;
              child_mask_next       = 8'd0;
              replies_expected_next = n;
              job.mask  = full;
              job.bkind = KIND_TOKEN;
              job.bval  = 16'd0;
            end
          end
        end
        OP_TOKEN: begin
          if (!tree_has_parent || {1'b0, tree_level} > ({1'b0, value} + 17'd1)) begin
            // adopt the sender as parent
            tree_parent_port_next = arrival_port;
            child_mask_next       = 8'd0;
            tree_level_next       = inc16(value);
            tree_has_parent_next  = 1'b1;
            tree_root_next        = 1'b0;
            replies_expected_next = n - 4'd1;
            if (n == 4'd1) begin
              job.ex_en  = 1'b1;
              job.ekind  = KIND_YES;
              job.eport  = arrival_port;
              job.evalue = inc16(value);
            end else begin
              job.mask  = full & ~port_bit;
              job.bkind = KIND_TOKEN;
              job.bval  = inc16(value);
            end
          end else begin
            job.ex_en  = 1'b1;
            job.ekind  = KIND_NO;
            job.eport  = arrival_port;
            job.evalue = inc16(value);
          end
        end
        OP_YES: begin
          if (replies_expected != 4'd0) begin
            if ({1'b0, value} == ({1'b0, tree_level} + 17'd1)) begin
              child_mask_next = child_mask | port_bit;
            end
            replies_expected_next = replies_expected - 4'd1;
            if (replies_expected == 4'd1) begin
              if (!tree_root) begin
                job.ex_en  = 1'b1;
                job.ekind  = KIND_YES;
                job.eport  = tree_parent_port;
                job.evalue = tree_level;
              end else begin
                done_flag_next = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    job.status.is_center = center_flag_next;
    job.status.bft_done  = done_flag_next;
    job.status.children  = child_mask_next;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= 4'd1;
    end else if (cfg_wen) begin
      port_count <= cfg_wdata;
    end
  end

  // Protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_ports    <= '0;
      top_value        <= '0;
      second_value     <= '0;
      top_port         <= '0;
      sat_parent_port  <= '0;
      available_flag   <= 1'b1;
      active_flag      <= 1'b0;
      processing_flag  <= 1'b0;
      center_flag      <= 1'b0;
      tree_has_parent  <= 1'b0;
      tree_root        <= 1'b0;
      tree_parent_port <= '0;
      tree_level       <= '0;
      replies_expected <= '0;
      child_mask       <= '0;
      done_flag        <= 1'b0;
    end else if (q_push) begin
      pending_ports    <= pending_ports_next;
      top_value        <= top_value_next;
      second_value     <= second_value_next;
      top_port         <= top_port_next;
      sat_parent_port  <= sat_parent_port_next;
      available_flag   <= available_flag_next;
      active_flag      <= active_flag_next;
      processing_flag  <= processing_flag_next;
      center_flag      <= center_flag_next;
      tree_has_parent  <= tree_has_parent_next;
      tree_root        <= tree_root_next;
      tree_parent_port <= tree_parent_port_next;
      tree_level       <= tree_level_next;
      replies_expected <= replies_expected_next;
      child_mask       <= child_mask_next;
      done_flag        <= done_flag_next;
    end
  end

endmodule
`default_nettype wire

@@ src/tcbn_queue.sv @@
// Two-entry job queue between the front end and the message sender.
`default_nettype none
module tcbn_queue import tcbn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output job_t      head
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ src/tcbn_back.sv @@
// Back end: expands one job into result transfers, one per cycle while out_stall is low, into an output register.
`default_nettype none
module tcbn_back import tcbn_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire job_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_port,
  output logic [15:0] out_value,
  output logic        last,
  output logic        is_center,
  output logic        bft_done,
  output logic [7:0]  tree_children
);

  logic       busy;
  job_t       cur;
  logic [7:0] rem, rem_after;
  logic       ex_pend, none_pend;
  logic       load_out;
  logic [2:0] low;

  assign q_pop     = !busy && !q_empty;
  assign load_out  = busy && (!out_valid || !out_stall);
  assign low       = lowest_bit(rem);
  assign rem_after = rem & ~(8'd1 << low);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop valid once the receiver takes the result and nothing new is loaded
      if (out_valid && !out_stall && !load_out) out_valid <= 1'b0;
      if (q_pop) begin
        // take the next job
        busy      <= 1'b1;
        cur       <= q_head;
        rem       <= q_head.mask;
        ex_pend   <= q_head.ex_en;
        none_pend <= (q_head.mask == 8'd0) && !q_head.ex_en;
      end else if (load_out) begin
        out_valid     <= 1'b1;
        is_center     <= cur.status.is_center;
        bft_done      <= cur.status.bft_done;
        tree_children <= cur.status.children;
        if (rem != 8'd0) begin
          out_kind  <= cur.bkind;
          out_port  <= low;
          out_value <= cur.bval;
          last      <= (rem_after == 8'd0) && !ex_pend;
          rem       <= rem_after;
          if (rem_after == 8'd0 && !ex_pend) busy <= 1'b0;
        end else if (ex_pend) begin
          out_kind  <= cur.ekind;
          out_port  <= cur.eport;
          out_value <= cur.evalue;
          last      <= 1'b1;
          ex_pend   <= 1'b0;
          busy      <= 1'b0;
        end else begin
          out_kind  <= KIND_NONE;
          out_port  <= 3'd0;
          out_value <= 16'd0;
          last      <= 1'b1;
          none_pend <= 1'b0;
          busy      <= !none_pend;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/tree_center_bft_node.sv @@
// Top level of the tree center / breadth-first tree node.
// Usage:
//   Input channel (in_valid/in_stall) carries one event per transfer: operation,
//   arrival_port and value. The front end classifies it in the accept cycle and
//   queues a job in a two-entry queue, so it stalls only when that queue is full.
//   Output channel (out_valid/out_stall) carries one outgoing message per
//   transfer; last marks the final result of an event, and the status fields
//   (is_center, bft_done, tree_children) show the state after that event.
//   An event yields one to eight results; an event with no message yields a
//   single result of kind none.
//   With an idle node, an event passes from the input through a queue entry
//   and the back end's job register into the output register.
//   Throughput: one result per cycle while out_stall is low, set by the back
//   end's port walk; it takes a new job only once the last result of its
//   current job is loaded. The user writes port_count through cfg_wen/cfg_wdata
//   only while the node is idle; the node does not enforce this. Reset (rst,
//   synchronous) clears the protocol state and port_count to 1.
//   When the receiver stalls, the output register holds its result and the
//   queue absorbs up to two more events before in_stall rises.
`default_nettype none
module tree_center_bft_node import tcbn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [2:0]  arrival_port,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_port,
  output logic [15:0]      out_value,
  output logic             last,
  output logic             is_center,
  output logic             bft_done,
  output logic [7:0]       tree_children
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;

  tcbn_front u_front (
    .clk, .rst, .cfg_wen, .cfg_wdata, .in_valid, .in_stall,
    .operation, .arrival_port, .value,
    .q_full, .q_push, .q_job(push_job)
  );

  tcbn_queue u_queue (
    .clk, .rst, .push(q_push), .push_job, .full(q_full), .empty(q_empty),
    .pop(q_pop), .head(head_job)
  );

  tcbn_back u_back (
    .clk, .rst, .q_empty, .q_head(head_job), .q_pop,
    .out_valid, .out_stall, .out_kind, .out_port, .out_value, .last,
    .is_center, .bft_done, .tree_children
  );

endmodule
`default_nettype wire
